[rtl/glfm_pkg.sv]
package glfm_pkg;

	// Design limits.
	localparam int MAX_COLS    = 512;
	localparam int PIXEL_WIDTH = 16;
	localparam int ROW_LIMIT   = 4096;

	// Field and register widths.
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int COLS_CFG_W  = $clog2(MAX_COLS + 1);
	localparam int ROW_W       = 12;
	localparam int ROWS_CFG_W  = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = ROWS_CFG_W;

	// Register indexes and reset values.
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = CFG_INDEX_W'(1);
	localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET    = ROWS_CFG_W'(512);
	localparam logic [COLS_CFG_W-1:0]  COLS_RESET    = COLS_CFG_W'(MAX_COLS);

	// Candidate peaks a single pixel can resolve, in delivery order.
	localparam int NUM_CAND  = 3;
	localparam int CAND_UP   = 0;
	localparam int CAND_LEFT = 1;
	localparam int CAND_SELF = 2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef logic signed [PIXEL_WIDTH-1:0] pixel_t;

	// One line buffer entry: the column's value in the previous row and the row before it.
	typedef struct packed {
		pixel_t newer;
		pixel_t older;
	} col_word_t;

	typedef enum logic [1:0] {
		FS_PRIME_ADDR0,
		FS_PRIME_ADDR1,
		FS_RUN
	} front_state_t;

	typedef struct packed {
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic [NUM_CAND-1:0] hit;
	} peak_job_t;

	typedef struct packed {
		logic      valid;
		peak_job_t job;
	} job_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/glfm_if.sv]
interface glfm_pixel_if;
	import glfm_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface glfm_peak_if;
	import glfm_pkg::*;

	logic             valid;
	logic             ready;
	logic [ROW_W-1:0] peak_row;
	logic [COL_W-1:0] peak_col;
	logic             last_of_run;

	modport source (output valid, output peak_row, output peak_col, output last_of_run,
		input ready);
	modport sink (input valid, input peak_row, input peak_col, input last_of_run,
		output ready);
endinterface

interface glfm_cfg_if;
	import glfm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/glfm_front.sv]
module glfm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	glfm_pixel_if.sink            pixels,
	glfm_cfg_if.sink              cfg,
	input  glfm_pkg::q_status_t   q_status,
	output glfm_pkg::job_push_t   push
);
	import glfm_pkg::*;

	logic [ROWS_CFG_W-1:0] rows_cfg_q;
	logic [COLS_CFG_W-1:0] cols_cfg_q;
	logic [ROWS_CFG_W-1:0] rows_eff;
	logic [COLS_CFG_W-1:0] cols_eff;

	front_state_t state_q;
	front_state_t state_d;
	logic         run;
	logic         load_a;
	logic [COL_W-1:0] prime_addr;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             row_last;
	logic             col_last;

	col_word_t mem [MAX_COLS];
	col_word_t rd_q;
	col_word_t a_q;
	col_word_t w1_q;
	col_word_t w2_q;
	col_word_t up_word;
	col_word_t right_word;
	col_word_t wr_word;

	pixel_t prev_q;
	pixel_t prev2_q;
	pixel_t prev_mid_q;
	pixel_t cur;
	pixel_t mid;
	pixel_t upup;
	pixel_t upright;

	logic [COLS_CFG_W:0] addr_sum;
	logic [COLS_CFG_W:0] addr_wrap;
	logic [COL_W-1:0]    rd_addr;
	logic                rd_en;

	logic cfg_write;
	logic cfg_hit;
	logic accept;
	logic [NUM_CAND-1:0] hit;

	// Out-of-range register values are pulled into range.
	always_comb begin
		rows_eff = rows_cfg_q;
		if (rows_cfg_q == '0) begin
			rows_eff = ROWS_CFG_W'(1);
		end else if (rows_cfg_q > ROWS_CFG_W'(ROW_LIMIT)) begin
			rows_eff = ROWS_CFG_W'(ROW_LIMIT);
		end
		cols_eff = cols_cfg_q;
		if (cols_cfg_q == '0) begin
			cols_eff = COLS_CFG_W'(1);
		end else if (cols_cfg_q > COLS_CFG_W'(MAX_COLS)) begin
			cols_eff = COLS_CFG_W'(MAX_COLS);
		end
	end

	assign cfg.ready = 1'b1;
	assign cfg_write = cfg.valid && cfg.ready;
	assign cfg_hit   = cfg_write && (cfg.index == REG_GRID_ROWS || cfg.index == REG_GRID_COLS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= ROWS_RESET;
			cols_cfg_q <= COLS_RESET;
		end else if (cfg_write) begin
			if (cfg.index == REG_GRID_ROWS) begin
				rows_cfg_q <= cfg.data[ROWS_CFG_W-1:0];
			end else if (cfg.index == REG_GRID_COLS) begin
				cols_cfg_q <= cfg.data[COLS_CFG_W-1:0];
			end
		end
	end

	// The prime sequence reloads the read window for column zero.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_PRIME_ADDR0: state_d = FS_PRIME_ADDR1;
			FS_PRIME_ADDR1: state_d = FS_RUN;
			FS_RUN:         state_d = FS_RUN;
			default:        state_d = FS_PRIME_ADDR0;
		endcase
		if (cfg_hit) begin
			state_d = FS_PRIME_ADDR0;
		end
	end

	always_comb begin
		run        = 1'b0;
		load_a     = 1'b0;
		prime_addr = '0;
		case (state_q)
			FS_PRIME_ADDR0: prime_addr = '0;
			FS_PRIME_ADDR1: begin
				load_a     = 1'b1;
				prime_addr = (cols_eff == COLS_CFG_W'(1)) ? '0 : COL_W'(1);
			end
			FS_RUN:         run = 1'b1;
			default:        prime_addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_PRIME_ADDR0;
		end else begin
			state_q <= state_d;
		end
	end

	assign pixels.ready = run && !q_status.full;
	assign accept       = pixels.valid && pixels.ready;

	assign row_last = ({1'b0, row_q} == rows_eff - ROWS_CFG_W'(1));
	assign col_last = ({1'b0, col_q} == cols_eff - COLS_CFG_W'(1));

	// With one or two columns the word needed was written too recently to come from
	// the memory, so it is taken from the last written words instead.
	always_comb begin
		if (cols_eff == COLS_CFG_W'(1)) begin
			up_word = w1_q;
		end else if (cols_eff == COLS_CFG_W'(2)) begin
			up_word = w2_q;
		end else begin
			up_word = a_q;
		end
		right_word = (cols_eff == COLS_CFG_W'(2)) ? w1_q : rd_q;
	end

	assign cur     = pixels.pixel_value;
	assign mid     = up_word.newer;
	assign upup    = up_word.older;
	assign upright = right_word.newer;
	assign wr_word = '{newer: cur, older: mid};

	// Pixel above is decided now that the one below it has arrived.
	assign hit[CAND_UP] = (row_q != '0) && (mid >= cur)
		&& ((row_q < ROW_W'(2)) || (mid >= upup))
		&& ((col_q == '0) || (mid >= prev_mid_q))
		&& (col_last || (mid >= upright));

	// In the last row the pixel to the left now has its right neighbor.
	assign hit[CAND_LEFT] = row_last && (col_q != '0) && (prev_q >= cur)
		&& ((row_q == '0) || (prev_q >= prev_mid_q))
		&& ((col_q < COL_W'(2)) || (prev_q >= prev2_q));

	// The final pixel of the grid has all its neighbors already.
	assign hit[CAND_SELF] = row_last && col_last
		&& ((row_q == '0) || (cur >= mid))
		&& ((col_q == '0) || (cur >= prev_q));

	assign push.valid   = accept && (hit != '0);
	assign push.job.row = row_q;
	assign push.job.col = col_q;
	assign push.job.hit = hit;

	// Read two columns ahead, wrapping at the row length.
	assign addr_sum  = (COLS_CFG_W + 1)'(col_q) + (COLS_CFG_W + 1)'(2);
	assign addr_wrap = (addr_sum >= {1'b0, cols_eff}) ? addr_sum - {1'b0, cols_eff} : addr_sum;
	assign rd_addr   = run ? addr_wrap[COL_W-1:0] : prime_addr;
	assign rd_en     = !run || accept;

	always_ff @(posedge clk) begin
		if (accept) begin
			mem[col_q] <= wr_word;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (load_a || accept) begin
			a_q <= rd_q;
		end
		if (accept) begin
			w1_q       <= wr_word;
			w2_q       <= w1_q;
			prev_q     <= cur;
			prev2_q    <= prev_q;
			prev_mid_q <= mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	a_accept_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (state_q == FS_RUN))
		else $error("pixel accepted while the read window was not primed");

endmodule

[rtl/glfm_queue.sv]
module glfm_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glfm_pkg::job_push_t   push,
	input  logic                  pop,
	output glfm_pkg::q_status_t   status,
	output glfm_pkg::peak_job_t   head
);
	import glfm_pkg::*;

	peak_job_t            slots_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_AW:0]    count_q;

	function automatic logic [QUEUE_AW-1:0] ptr_next(input logic [QUEUE_AW-1:0] p);
		ptr_next = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
	endfunction

	assign status.full  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slots_q[wr_ptr_q] <= push.job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (pop && !push.valid) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !status.full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("job popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
		else $error("queue count beyond its depth");

endmodule

[rtl/glfm_back.sv]
module glfm_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glfm_pkg::q_status_t   q_status,
	input  glfm_pkg::peak_job_t   head,
	output logic                  pop,
	glfm_peak_if.source           peaks
);
	import glfm_pkg::*;

	logic [NUM_CAND-1:0] done_q;
	logic [NUM_CAND-1:0] rem;
	logic [NUM_CAND-1:0] pick;
	logic                last;
	logic                load;
	logic [ROW_W-1:0]    pick_row;
	logic [COL_W-1:0]    pick_col;

	logic             out_valid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_last_q;

	// Candidates still to be delivered for the job at the head; lowest first.
	assign rem  = head.hit & ~done_q;
	assign pick = rem & ~(rem - NUM_CAND'(1));
	assign last = ((rem & ~pick) == '0);

	always_comb begin
		pick_row = head.row;
		pick_col = head.col;
		if (pick[CAND_UP]) begin
			pick_row = head.row - ROW_W'(1);
		end else if (pick[CAND_LEFT]) begin
			pick_col = head.col - COL_W'(1);
		end
	end

	assign load = !q_status.empty && (!out_valid_q || peaks.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				done_q <= last ? '0 : (done_q | pick);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (peaks.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_row_q  <= pick_row;
			out_col_q  <= pick_col;
			out_last_q <= last;
		end
	end

	assign peaks.valid       = out_valid_q;
	assign peaks.peak_row    = out_row_q;
	assign peaks.peak_col    = out_col_q;
	assign peaks.last_of_run = out_last_q;

	a_head_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		!q_status.empty |-> (rem != '0))
		else $error("queued job has no peak left to deliver");

endmodule

[rtl/grid_local_maximum_finder_top.sv]
// Four-neighbor peak finder for a grid of signed pixels that arrive in raster order. Every
// pixel that is greater than or equal to each of its up, down, left and right neighbors that
// lie inside the grid is reported as one transfer carrying its row and column; ties count, so
// a plateau gives several peaks. A pixel is decided once its lower neighbor arrives, so peaks
// of the last two rows can come out of raster order: for each pixel the block reports, in
// this order, the pixel above it, then (in the last row) the pixel to its left, then (for the
// last pixel of the grid) the pixel itself, and marks the final peak caused by that pixel with
// last_of_run. The input takes one pixel per clock while the result side keeps up; each pixel
// may cause up to three peaks but the result port moves one per clock, and a four-entry queue
// of decided pixels absorbs bursts before the input is held off. The first peak of a pixel is
// offered on the result port once it has passed the job queue and the output register. The
// sustained rate of one pixel per clock is set by the line buffer memory, which has one write
// and one read per accepted pixel. After reset and after each size register write the block
// reloads its read window from the line buffer and holds the input off meanwhile; register
// writes are always taken, and size writes restart the grid at row zero, column zero.
module grid_local_maximum_finder_top (
	input  logic        clk,
	input  logic        arst_n,
	glfm_pixel_if.sink  pixels,
	glfm_peak_if.source peaks,
	glfm_cfg_if.sink    cfg
);
	import glfm_pkg::*;

	job_push_t push;
	q_status_t q_status;
	peak_job_t head;
	logic      pop;

	// Front: counters, line buffer and neighbor compares; produces one job per pixel that
	// resolves at least one peak.
	glfm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixels   (pixels),
		.cfg      (cfg),
		.q_status (q_status),
		.push     (push)
	);

	// Short job queue so that the front and the result side stall independently.
	glfm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.status (q_status),
		.head   (head)
	);

	// Back: unpacks each job into one result transfer per peak through an output register.
	glfm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.head     (head),
		.pop      (pop),
		.peaks    (peaks)
	);

endmodule

[tb/glfm_peak_checker.sv]
`timescale 1ns / 100ps

// Watches the pixel, peak and register channels, keeps its own copy of the line
// buffers and counters, and compares every peak transfer with the oldest expected one.
module glfm_peak_checker (
	input  logic  clk,
	input  logic  arst_n,
	glfm_pixel_if pixels,
	glfm_peak_if  peaks,
	glfm_cfg_if   cfg,
	output int    mismatches,
	output int    outstanding
);
	import glfm_pkg::*;

	localparam int PRINT_LIMIT = 100;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} peak_rec_t;

	pixel_t                  two_rows_up [MAX_COLS];
	pixel_t                  one_row_up [MAX_COLS];
	pixel_t                  left_pixel;
	int                      row_pos;
	int                      col_pos;
	logic [ROWS_CFG_W-1:0]   rows_reg;
	logic [COLS_CFG_W-1:0]   cols_reg;
	peak_rec_t               peaks_due[$];

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_LIMIT)
			$display("%0t ns: peak mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic peak_rec_t peak_at(input int r, input int c);
		peak_rec_t p;
		p.row  = ROW_W'(r);
		p.col  = COL_W'(c);
		p.last = 1'b0;
		return p;
	endfunction

	// Decides every pixel whose last neighbor is the incoming one.
	task automatic predict_peaks(input pixel_t px);
		int        n_rows;
		int        n_cols;
		int        r;
		int        c;
		pixel_t    above;
		logic      ok;
		peak_rec_t found[$];

		n_rows = (rows_reg == 0) ? 1 : (rows_reg > ROW_LIMIT) ? ROW_LIMIT : int'(rows_reg);
		n_cols = (cols_reg == 0) ? 1 : (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
		r = (row_pos >= n_rows) ? 0 : row_pos;
		c = (col_pos >= n_cols) ? 0 : col_pos;
		above = one_row_up[c];

		if (r >= 1) begin
			ok = (above >= px);
			if (r >= 2) ok = ok && (above >= two_rows_up[c]);
			if (c >= 1) ok = ok && (above >= two_rows_up[c-1]);
			if (c + 1 < n_cols) ok = ok && (above >= one_row_up[c+1]);
			if (ok) found.push_back(peak_at(r - 1, c));
		end

		two_rows_up[c] = above;
		one_row_up[c]  = px;

		if (r == n_rows - 1) begin
			if (c >= 1) begin
				ok = (left_pixel >= px);
				if (r >= 1) ok = ok && (left_pixel >= two_rows_up[c-1]);
				if (c >= 2) ok = ok && (left_pixel >= one_row_up[c-2]);
				if (ok) found.push_back(peak_at(r, c - 1));
			end
			if (c == n_cols - 1) begin
				ok = 1'b1;
				if (r >= 1) ok = ok && (px >= above);
				if (c >= 1) ok = ok && (px >= left_pixel);
				if (ok) found.push_back(peak_at(r, c));
			end
		end

		left_pixel = px;
		if (c + 1 >= n_cols) begin
			col_pos = 0;
			row_pos = (r + 1 >= n_rows) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end

		if (found.size() > 0) found[found.size()-1].last = 1'b1;
		foreach (found[i]) peaks_due.push_back(found[i]);
	endtask

	task automatic check_peak();
		peak_rec_t want;

		if (peaks_due.size() == 0) begin
			report_mismatch($sformatf("unexpected peak row %0d col %0d",
				peaks.peak_row, peaks.peak_col));
		end else begin
			want = peaks_due.pop_front();
			if (peaks.peak_row !== want.row)
				report_mismatch($sformatf("peak_row %0d, expected %0d (col %0d)",
					peaks.peak_row, want.row, want.col));
			if (peaks.peak_col !== want.col)
				report_mismatch($sformatf("peak_col %0d, expected %0d (row %0d)",
					peaks.peak_col, want.col, want.row));
			if (peaks.last_of_run !== want.last)
				report_mismatch($sformatf("last_of_run %0b, expected %0b at row %0d col %0d",
					peaks.last_of_run, want.last, want.row, want.col));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (two_rows_up[i]) begin
				two_rows_up[i] = '0;
				one_row_up[i]  = '0;
			end
			left_pixel = '0;
			row_pos    = 0;
			col_pos    = 0;
			rows_reg   = ROWS_RESET;
			cols_reg   = COLS_RESET;
			peaks_due.delete();
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_GRID_ROWS) begin
					rows_reg = cfg.data[ROWS_CFG_W-1:0];
					row_pos  = 0;
					col_pos  = 0;
				end else if (cfg.index == REG_GRID_COLS) begin
					cols_reg = cfg.data[COLS_CFG_W-1:0];
					row_pos  = 0;
					col_pos  = 0;
				end
			end
			// A peak can never stem from the pixel taken at the same edge.
			if (peaks.valid && peaks.ready) check_peak();
			if (pixels.valid && pixels.ready) predict_peaks(pixels.pixel_value);
			outstanding <= peaks_due.size();
		end
	end

endmodule

[tb/grid_local_maximum_finder_top_tb.sv]
`timescale 1ns / 100ps

// Stimulus and verdict for the grid peak finder. The checker beside the block does all of
// the prediction and comparison; this module only decides what pixels and register writes
// go in, how both sides of the block idle, and whether the run passed.
module grid_local_maximum_finder_top_tb;
	import glfm_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 100;
	localparam int RANDOM_ITEMS  = 220;
	localparam int CALM_ITEMS    = 60;
	localparam int TIMEOUT_NS    = 3_000_000;

	// Register slots past the end of the map; writes there must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LO = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HI = CFG_INDEX_W'(3);

	localparam pixel_t PIX_MAX = {1'b0, {(PIXEL_WIDTH-1){1'b1}}};
	localparam pixel_t PIX_MIN = {1'b1, {(PIXEL_WIDTH-1){1'b0}}};

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;

	// When calm is set neither side idles. A rising squeeze_req makes the result side
	// hold off for a long stretch while the pixel side keeps offering.
	bit calm        = 1'b0;
	bit squeeze_req = 1'b0;

	// Effective grid size after the last pair of register writes.
	int grid_h;
	int grid_w;

	// A single peak in the middle of a 3x3 grid; its four neighbors sit above the corners.
	pixel_t hill [9] = '{1, 2, 1, 2, 9, 2, 1, 2, 1};

	glfm_pixel_if pix_if ();
	glfm_peak_if  peak_if ();
	glfm_cfg_if   cfg_if ();

	grid_local_maximum_finder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_if),
		.peaks  (peak_if),
		.cfg    (cfg_if)
	);

	glfm_peak_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pix_if),
		.peaks       (peak_if),
		.cfg         (cfg_if),
		.mismatches  (mismatches),
		.outstanding (pending)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the block stops moving transfers altogether.
	initial begin
		#(TIMEOUT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side. It stalls about one cycle in four, except while calm, and takes one long
	// break per rising squeeze_req. The long break is counted here, in this process, so the
	// pixel side is free to keep offering and drive the block into back-pressure.
	initial begin : result_side
		int hold_left;
		bit squeeze_seen;

		hold_left    = 0;
		squeeze_seen = 1'b0;
		peak_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_seen) begin
				squeeze_seen = 1'b1;
				hold_left    = LONG_HOLD;
			end
			if (!squeeze_req) squeeze_seen = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
				peak_if.ready <= 1'b0;
			end else if (calm) begin
				peak_if.ready <= 1'b1;
			end else begin
				peak_if.ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	function automatic pixel_t rand_pixel(input int spread);
		if (spread == 0) return pixel_t'($urandom);
		return pixel_t'(int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// Offers one pixel and returns at the edge where its transfer happens. A random gap
	// may come first; valid stays high between back-to-back pixels.
	task automatic push_pixel(input pixel_t value);
		if (!calm && $urandom_range(0, 99) < 25) begin
			pix_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 25);
		end
		pix_if.valid       <= 1'b1;
		pix_if.pixel_value <= value;
		do @(posedge clk); while (!pix_if.ready);
	endtask

	task automatic feed(input int count, input int spread);
		for (int i = 0; i < count; i++) push_pixel(rand_pixel(spread));
	endtask

	// Stops offering pixels and waits until every expected peak has been seen, then keeps
	// waiting so that a pixel still in flight with no peak of its own has left the pipe.
	task automatic settle();
		pix_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only happen with the block idle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Writes both size registers in a random order and notes the size the block will use:
	// zero acts as one, and anything past the limit acts as the limit. The column register
	// only keeps its low bits.
	task automatic set_grid(input logic [CFG_DATA_W-1:0] rows_val,
			input logic [CFG_DATA_W-1:0] cols_val);
		logic [COLS_CFG_W-1:0] cols_kept;

		cols_kept = cols_val[COLS_CFG_W-1:0];
		if ($urandom_range(0, 1)) begin
			write_reg(REG_GRID_ROWS, rows_val);
			write_reg(REG_GRID_COLS, cols_val);
		end else begin
			write_reg(REG_GRID_COLS, cols_val);
			write_reg(REG_GRID_ROWS, rows_val);
		end
		grid_h = (rows_val == 0) ? 1 : (rows_val > ROW_LIMIT) ? ROW_LIMIT : int'(rows_val);
		grid_w = (cols_kept == 0) ? 1 : (cols_kept > MAX_COLS) ? MAX_COLS : int'(cols_kept);
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] rows_val;
		logic [CFG_DATA_W-1:0] cols_val;
		int                    count;
		int                    spread;
		int                    phase;
		int                    random_sent;

		arst_n             = 1'b0;
		pix_if.valid       = 1'b0;
		pix_if.pixel_value = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = '0;
		cfg_if.data        = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset sizing is 512 by 512, so nothing in row zero is decided yet: field extremes
		// go in and no peak may come out before the grid is resized.
		push_pixel(PIX_MAX);
		push_pixel(PIX_MIN);
		push_pixel(pixel_t'(0));
		push_pixel(pixel_t'(-1));
		push_pixel(pixel_t'(1));
		push_pixel(PIX_MAX);
		push_pixel(PIX_MAX);
		push_pixel(PIX_MIN);

		// Zero in both size registers gives a one-pixel grid: every pixel is its own peak.
		set_grid('0, '0);
		push_pixel(PIX_MAX);
		push_pixel(PIX_MIN);
		push_pixel(pixel_t'(0));

		// A single flat row: ties count, so every pixel is a peak.
		set_grid(CFG_DATA_W'(1), CFG_DATA_W'(4));
		repeat (4) push_pixel(pixel_t'(5));

		// 3x3 hill, interrupted halfway by a write to an unmapped slot, which must not
		// restart the grid. Then a flat 3x3 grid at the most negative value.
		set_grid(CFG_DATA_W'(3), CFG_DATA_W'(3));
		for (int i = 0; i < 4; i++) push_pixel(hill[i]);
		write_reg(REG_UNUSED_LO, '1);
		for (int i = 4; i < 9; i++) push_pixel(hill[i]);
		repeat (9) push_pixel(PIX_MIN);

		// A column write in the middle of a grid restarts it at row zero, column zero.
		push_pixel(PIX_MAX);
		push_pixel(PIX_MAX);
		write_reg(REG_GRID_COLS, CFG_DATA_W'(3));
		foreach (hill[i]) push_pixel(hill[i]);
		write_reg(REG_UNUSED_HI, '0);

		// Column data with bits above the register width: only the low bits are kept.
		set_grid(CFG_DATA_W'(2), CFG_DATA_W'(13'h1C03));
		feed(2 * grid_w, 2);

		// One column and a row count past the limit: the first rows of the clamped grid.
		set_grid('1, CFG_DATA_W'(1));
		feed(6, 2);

		// A column count past the limit gives the widest row. A single row, so every pixel
		// but the newest is decided while the row is still short.
		set_grid(CFG_DATA_W'(1), CFG_DATA_W'(1023));
		feed(24, 1);

		// Back-pressure: one peak per pixel while the result side takes a long break and the
		// pixel side keeps offering, so the block's queue fills and holds the input off.
		set_grid(CFG_DATA_W'(1), CFG_DATA_W'(1));
		calm        = 1'b1;
		squeeze_req = 1'b1;
		feed(40, 0);
		squeeze_req = 1'b0;
		calm        = 1'b0;

		// Random small grids, mostly whole grids of small values so that ties and plateaus
		// are common, with some full-range content and some grids cut short by the next
		// register write. The second phase runs with no idling on either side.
		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			rows_val = CFG_DATA_W'($urandom_range(0, 6));
			cols_val = CFG_DATA_W'($urandom_range(0, 8));
			if ($urandom_range(0, 5) == 0)
				cols_val = cols_val | (CFG_DATA_W'($urandom_range(1, 7)) << COLS_CFG_W);
			set_grid(rows_val, cols_val);
			spread = ($urandom_range(0, 9) < 7) ? 2 : 0;
			count  = grid_h * grid_w * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0) count += $urandom_range(1, grid_h * grid_w);
			calm = (phase == 1);
			if (calm) count = CALM_ITEMS;
			feed(count, spread);
			calm = 1'b0;
			random_sent += count;
			phase++;
		end

		settle();
		if (mismatches == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
rtl/glfm_pkg.sv
rtl/glfm_if.sv
rtl/glfm_front.sv
rtl/glfm_queue.sv
rtl/glfm_back.sv
rtl/grid_local_maximum_finder_top.sv
tb/glfm_peak_checker.sv
tb/grid_local_maximum_finder_top_tb.sv
